// ===== hw/rtl/mesh_route_table_engine_macros.svh =====
// Assertion helpers shared by the routing table engine.
`ifndef MESH_ROUTE_TABLE_ENGINE_MACROS_SVH
`define MESH_ROUTE_TABLE_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRTE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mrte_pkg.sv =====
package mrte_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_BEACON = 2'd0;
   localparam logic [1:0] KIND_ROUTE  = 2'd1;
   localparam logic [1:0] KIND_SEND   = 2'd2;
   localparam logic [1:0] KIND_TICK   = 2'd3;

   // Result status codes.
   localparam logic [3:0] STATUS_UPDATED  = 4'd0;
   localparam logic [3:0] STATUS_FULL     = 4'd1;
   localparam logic [3:0] STATUS_LOCAL    = 4'd2;
   localparam logic [3:0] STATUS_FORWARD  = 4'd3;
   localparam logic [3:0] STATUS_HOP_DROP = 4'd4;
   localparam logic [3:0] STATUS_NO_ROUTE = 4'd5;
   localparam logic [3:0] STATUS_SENT     = 4'd6;
   localparam logic [3:0] STATUS_DISABLED = 4'd7;
   localparam logic [3:0] STATUS_IDLE     = 4'd8;
   localparam logic [3:0] STATUS_BEACON   = 4'd9;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_NODE_ID   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESH_ON         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HOP_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTE_TIMEOUT   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEACON_INTERVAL = 3'd4;

   // Hop count values with a special meaning.
   localparam logic [7:0] HOP_NONE = 8'd255;
   localparam logic [7:0] HOP_ONE  = 8'd1;

   // A beacon run lists at most this many neighbors.
   localparam int unsigned RUN_CNT_W = 5;
   localparam logic [RUN_CNT_W-1:0] RUN_MAX = 5'd16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  node_id;
      logic [7:0]  hops_in;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [7:0]  next_hop_id;
      logic [7:0]  hops_out;
      logic [15:0] seq_out;
      logic [7:0]  neighbor_id;
      logic        neighbor_valid;
      logic        last;
   } rsp_type;

   // Operation carried by the probe through the cell chain.
   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_BEACON = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   // Probe handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic        valid;
      op_type      op;
      logic        due;
      logic        matched;
      logic [7:0]  node;
      logic [7:0]  hops;
      logic [31:0] now;
      logic [7:0]  best_hops;
      logic [7:0]  best_next;
   } probe_type;

   // Neighbor reported by a cell during a beacon pass.
   typedef struct packed {
      logic       valid;
      logic [7:0] id;
   } nbr_type;

endpackage

// ===== hw/rtl/mrte_cell.sv =====
module mrte_cell
   import mrte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] timeout_ms,
   input  probe_type   probe_in,
   output probe_type   probe_out,
   output nbr_type     nbr
);

   logic        used_ff, used_in;
   logic        active_ff, active_in;
   logic [7:0]  node_ff, node_in;
   logic [7:0]  ent_hops_ff, ent_hops_in;
   logic [7:0]  next_ff, next_in;
   logic [31:0] stamp_ff, stamp_in;
   probe_type   probe_ff, probe_in_next;
   nbr_type     nbr_in;

   logic        match;
   logic [31:0] age;
   logic        expire;

   // Entry compare and age against the visiting probe.
   assign match  = used_ff && (node_ff == probe_in.node);
   assign age    = probe_in.now - stamp_ff;
   assign expire = active_ff && (age > timeout_ms);

   // Work on the probe that sits at this cell's input this cycle.
   always_comb begin
      used_in       = used_ff;
      active_in     = active_ff;
      node_in       = node_ff;
      ent_hops_in   = ent_hops_ff;
      next_in       = next_ff;
      stamp_in      = stamp_ff;
      probe_in_next = probe_in;
      nbr_in        = '0;
      if (probe_in.valid) begin
         case (probe_in.op)
            OP_BEACON: begin
               // The first entry that either matches or is free takes the beacon.
               if (!probe_in.matched && (match || !used_ff)) begin
                  used_in       = 1'b1;
                  node_in       = probe_in.node;
                  ent_hops_in   = probe_in.hops;
                  stamp_in      = probe_in.now;
                  active_in     = 1'b1;
                  if (probe_in.hops == HOP_ONE) begin
                     next_in = probe_in.node;
                  end
                  probe_in_next.matched = 1'b1;
               end
            end
            OP_LOOKUP: begin
               // Keep the earliest entry with the fewest hops.
               if (match && active_ff && (ent_hops_ff < probe_in.best_hops)) begin
                  probe_in_next.best_hops = ent_hops_ff;
                  probe_in_next.best_next = next_ff;
               end
            end
            OP_TICK: begin
               // Age out a stale entry, then report a live one-hop neighbor.
               if (expire) begin
                  active_in = 1'b0;
               end
               if (probe_in.due && active_ff && !expire && (ent_hops_ff == HOP_ONE)) begin
                  nbr_in.valid = 1'b1;
                  nbr_in.id    = node_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state, the next hop and the probe register are cleared; the entry
   // data is written before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= 1'b0;
         active_ff <= 1'b0;
         next_ff   <= '0;
         probe_ff  <= '0;
      end else begin
         used_ff   <= used_in;
         active_ff <= active_in;
         next_ff   <= next_in;
         probe_ff  <= probe_in_next;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      ent_hops_ff <= ent_hops_in;
      stamp_ff    <= stamp_in;
   end

   assign probe_out = probe_ff;
   assign nbr       = nbr_in;

endmodule

// ===== hw/rtl/mesh_route_table_engine.sv =====
// Mesh routing table engine. The table lives in a row of MAX_NODES cells, one
// entry per cell. Every request sends a probe down the row, one cell per clock,
// so busy stays high while the probe walks the row, and the final result is
// shown in the cycle in which busy has fallen; the next request can be
// taken in the cycle that shows that final result. A beacon run streams its
// neighbor results while the probe walks the row, each held until a later one
// is found or the run closes, with last set on the final one. Results are shown on
// rsp_valid for a single cycle and cannot be held off, so the receiver must take
// every strobe. Configuration writes are always ready and belong in idle time.
`include "mesh_route_table_engine_macros.svh"

module mesh_route_table_engine
   import mrte_pkg::*;
#(
   parameter int unsigned MAX_NODES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;

   logic [7:0]            local_id_ff, local_id_in;
   logic                  mesh_on_ff, mesh_on_in;
   logic [7:0]            hop_limit_ff, hop_limit_in;
   logic [31:0]           timeout_ff, timeout_in;
   logic [31:0]           interval_ff, interval_in;

   logic [15:0]           sequence_ff, sequence_in;
   logic [31:0]           beacon_stamp_ff, beacon_stamp_in;

   logic [1:0]            job_kind_ff, job_kind_in;
   logic                  job_fixed_ff, job_fixed_in;
   logic [3:0]            job_status_ff, job_status_in;
   logic                  job_due_ff, job_due_in;
   logic [7:0]            job_hops_ff, job_hops_in;
   logic [15:0]           job_seq_ff, job_seq_in;

   logic                  pend_valid_ff, pend_valid_in;
   logic [7:0]            pend_id_ff, pend_id_in;
   logic [RUN_CNT_W-1:0]  run_count_ff, run_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   probe_type             launch_ff, launch_in;
   probe_type             chain [MAX_NODES+1];
   nbr_type               nbr [MAX_NODES];
   logic [MAX_NODES:0]    in_flight;
   probe_type             tail;

   logic                  accept;
   logic                  csr_write;
   logic [7:0]            hops_next;
   logic [31:0]           beacon_age;
   logic                  beacon_due;
   logic                  route_found;
   logic                  nbr_valid;
   logic [7:0]            nbr_id;

   assign accept     = start && (state_ff == S_IDLE);
   assign csr_write  = csr_valid && csr_ready;
   assign hops_next  = req_data.hops_in + HOP_ONE;
   assign beacon_age = req_data.now_ms - beacon_stamp_ff;
   assign beacon_due = beacon_age > interval_ff;

   // Row of table cells; the probe enters at cell zero.
   assign chain[0] = launch_ff;

   for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
      mrte_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .timeout_ms (timeout_ff),
         .probe_in   (chain[g]),
         .probe_out  (chain[g+1]),
         .nbr        (nbr[g])
      );
   end

   for (genvar g = 0; g <= MAX_NODES; g++) begin : g_flight
      assign in_flight[g] = chain[g].valid;
   end

   assign tail        = chain[MAX_NODES];
   assign route_found = tail.best_hops != HOP_NONE;

   // Only the cell holding the probe can report, so an OR picks it out.
   always_comb begin
      nbr_valid = 1'b0;
      nbr_id    = '0;
      for (int i = 0; i < MAX_NODES; i++) begin
         nbr_valid = nbr_valid | nbr[i].valid;
         nbr_id    = nbr_id | nbr[i].id;
      end
   end

   // Configuration register writes.
   always_comb begin
      local_id_in  = local_id_ff;
      mesh_on_in   = mesh_on_ff;
      hop_limit_in = hop_limit_ff;
      timeout_in   = timeout_ff;
      interval_in  = interval_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LOCAL_NODE_ID:   local_id_in  = csr_wdata[7:0];
            CSR_MESH_ON:         mesh_on_in   = csr_wdata[0];
            CSR_MAX_HOP_LIMIT:   hop_limit_in = csr_wdata[7:0];
            CSR_ROUTE_TIMEOUT:   timeout_in   = csr_wdata;
            CSR_BEACON_INTERVAL: interval_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request decode, probe launch, neighbor run and final result.
   always_comb begin
      state_in        = state_ff;
      sequence_in     = sequence_ff;
      beacon_stamp_in = beacon_stamp_ff;
      job_kind_in     = job_kind_ff;
      job_fixed_in    = job_fixed_ff;
      job_status_in   = job_status_ff;
      job_due_in      = job_due_ff;
      job_hops_in     = job_hops_ff;
      job_seq_in      = job_seq_ff;
      pend_valid_in   = pend_valid_ff;
      pend_id_in      = pend_id_ff;
      run_count_in    = run_count_ff;
      rsp_valid_in    = 1'b0;
      rsp_data_in     = '0;

      launch_in           = '0;
      launch_in.node      = req_data.node_id;
      launch_in.hops      = hops_next;
      launch_in.now       = req_data.now_ms;
      launch_in.best_hops = HOP_NONE;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in        = S_SCAN;
               launch_in.valid = 1'b1;
               job_kind_in     = req_data.kind;
               job_fixed_in    = 1'b0;
               job_status_in   = STATUS_IDLE;
               job_due_in      = 1'b0;
               job_hops_in     = hops_next;
               pend_valid_in   = 1'b0;
               run_count_in    = '0;
               case (req_data.kind)
                  KIND_BEACON: begin
                     launch_in.op = OP_BEACON;
                  end
                  KIND_ROUTE: begin
                     if (req_data.node_id == local_id_ff) begin
                        job_fixed_in  = 1'b1;
                        job_status_in = STATUS_LOCAL;
                     end else if (req_data.hops_in >= hop_limit_ff) begin
                        job_fixed_in  = 1'b1;
                        job_status_in = STATUS_HOP_DROP;
                     end else begin
                        launch_in.op = OP_LOOKUP;
                     end
                  end
                  KIND_SEND: begin
                     if (mesh_on_ff) begin
                        launch_in.op = OP_LOOKUP;
                     end else begin
                        job_fixed_in  = 1'b1;
                        job_status_in = STATUS_DISABLED;
                     end
                  end
                  default: begin
                     // Time tick: aging runs whenever the mesh is on, a beacon only when due.
                     if (mesh_on_ff) begin
                        launch_in.op  = OP_TICK;
                        launch_in.due = beacon_due;
                        job_due_in    = beacon_due;
                        if (beacon_due) begin
                           job_seq_in      = sequence_ff;
                           sequence_in     = sequence_ff + 16'd1;
                           beacon_stamp_in = req_data.now_ms;
                        end
                     end else begin
                        job_fixed_in  = 1'b1;
                        job_status_in = STATUS_DISABLED;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // A new neighbor releases the one held before it.
            if (nbr_valid && (run_count_ff < RUN_MAX)) begin
               if (pend_valid_ff) begin
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.status          = STATUS_BEACON;
                  rsp_data_in.seq_out         = job_seq_ff;
                  rsp_data_in.neighbor_id     = pend_id_ff;
                  rsp_data_in.neighbor_valid  = 1'b1;
               end
               pend_valid_in = 1'b1;
               pend_id_in    = nbr_id;
               run_count_in  = run_count_ff + 1'b1;
            end
            // The probe has left the last cell: close the request.
            if (tail.valid) begin
               state_in         = S_IDLE;
               rsp_valid_in     = 1'b1;
               rsp_data_in.last = 1'b1;
               if (job_fixed_ff) begin
                  rsp_data_in.status = job_status_ff;
               end else begin
                  case (job_kind_ff)
                     KIND_BEACON: begin
                        rsp_data_in.status = tail.matched ? STATUS_UPDATED : STATUS_FULL;
                     end
                     KIND_ROUTE: begin
                        if (route_found) begin
                           rsp_data_in.status      = STATUS_FORWARD;
                           rsp_data_in.next_hop_id = tail.best_next;
                           rsp_data_in.hops_out    = job_hops_ff;
                        end else begin
                           rsp_data_in.status = STATUS_NO_ROUTE;
                        end
                     end
                     KIND_SEND: begin
                        if (route_found) begin
                           rsp_data_in.status      = STATUS_SENT;
                           rsp_data_in.next_hop_id = tail.best_next;
                           rsp_data_in.seq_out     = sequence_ff;
                           sequence_in             = sequence_ff + 16'd1;
                        end else begin
                           rsp_data_in.status = STATUS_NO_ROUTE;
                        end
                     end
                     default: begin
                        if (job_due_ff) begin
                           rsp_data_in.status         = STATUS_BEACON;
                           rsp_data_in.seq_out        = job_seq_ff;
                           rsp_data_in.neighbor_id    = pend_valid_ff ? pend_id_ff : 8'd0;
                           rsp_data_in.neighbor_valid = pend_valid_ff;
                        end else begin
                           rsp_data_in.status = STATUS_IDLE;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         local_id_ff     <= 8'd0;
         mesh_on_ff      <= 1'b0;
         hop_limit_ff    <= 8'd8;
         timeout_ff      <= 32'd30000;
         interval_ff     <= 32'd5000;
         sequence_ff     <= '0;
         beacon_stamp_ff <= '0;
         pend_valid_ff   <= 1'b0;
         run_count_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         launch_ff       <= '0;
      end else begin
         state_ff        <= state_in;
         local_id_ff     <= local_id_in;
         mesh_on_ff      <= mesh_on_in;
         hop_limit_ff    <= hop_limit_in;
         timeout_ff      <= timeout_in;
         interval_ff     <= interval_in;
         sequence_ff     <= sequence_in;
         beacon_stamp_ff <= beacon_stamp_in;
         pend_valid_ff   <= pend_valid_in;
         run_count_ff    <= run_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         launch_ff       <= launch_in;
      end
   end

   // Request context, held neighbor and result payload.
   always_ff @(posedge clock) begin
      job_kind_ff         <= job_kind_in;
      job_fixed_ff        <= job_fixed_in;
      job_status_ff       <= job_status_in;
      job_due_ff          <= job_due_in;
      job_hops_ff         <= job_hops_in;
      job_seq_ff          <= job_seq_in;
      pend_id_ff          <= pend_id_in;
      rsp_data_ff         <= rsp_data_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Only one probe may walk the row at a time.
   `MRTE_ASSERT_SAME(a_one_probe, clock, reset, 1'b1, $onehot0(in_flight),
      "more than one probe in the cell row")
   // A probe in the row means a request is open.
   `MRTE_ASSERT_SAME(a_probe_busy, clock, reset, |in_flight, state_ff == S_SCAN,
      "probe in the cell row while idle")
   // The closing result of a request is shown once the engine is idle again.
   `MRTE_ASSERT_SAME(a_last_idle, clock, reset, rsp_valid && rsp_data.last, !busy,
      "closing result shown while still busy")
   // Results before the closing one are always beacon neighbors.
   `MRTE_ASSERT_SAME(a_run_entry, clock, reset, rsp_valid && !rsp_data.last,
      busy && (rsp_data.status == STATUS_BEACON) && rsp_data.neighbor_valid,
      "non-final result is not a beacon neighbor")
   // A taken request launches a probe into the row.
   `MRTE_ASSERT_NEXT(a_launch, clock, reset, start && !busy,
      launch_ff.valid && busy, "request taken without launching a probe")

endmodule
